// ===== rtl/ring_buffer_deque_defines.svh =====
// ----------------------------------------------------------------------------
// ring_buffer_deque assertion macros
// shared assertion forms for the deque rtl
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// checked only out of reset
`define RBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define RBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// sizes, codes, types and pointer helpers of the ring buffer deque
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // port field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);
  localparam ptr_t PTR_LAST  = PTR_W'(DEPTH - 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic  we;
    logic  re;
    ptr_t  addr;
    data_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic    pop_ok;
    status_e status;
    cnt_t    occ;
  } result_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : ptr_t'(p - 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// pointer and count control, memory requests and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_buffer_deque_defines.svh"

module rbd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rbd_pkg::opcode_e opcode_i,
  input  wire rbd_pkg::data_t   value_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rbd_pkg::result_t      res_o,
  output rbd_pkg::ram_req_t     ram_req_o
);

  import rbd_pkg::*;

  ptr_t    back_q, back_d;
  ptr_t    front_q, front_d;
  cnt_t    cnt_q, cnt_d;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    acc;
  logic    full, empty;
  logic    is_push;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign full       = (cnt_q == DEPTH_CNT);
  assign empty      = (cnt_q == '0);
  assign is_push    = (opcode_i == OP_PUSH_BACK) || (opcode_i == OP_PUSH_FRONT);

  always_comb begin
    back_d          = back_q;
    front_d         = front_q;
    cnt_d           = cnt_q;
    res_d           = res_q;
    ram_req_o       = '0;
    ram_req_o.wdata = value_i;
    if (acc) begin
      res_d.pop_ok = 1'b0;
      res_d.status = ST_DONE;
      unique case (opcode_i)
        OP_PUSH_BACK: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            back_d         = ptr_dec(back_q);
            ram_req_o.we   = 1'b1;
            ram_req_o.addr = back_d;
            cnt_d          = cnt_t'(cnt_q + 1'b1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            front_d        = ptr_inc(front_q);
            ram_req_o.we   = 1'b1;
            ram_req_o.addr = front_d;
            cnt_d          = cnt_t'(cnt_q + 1'b1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = back_q;
            back_d         = ptr_inc(back_q);
            res_d.pop_ok   = 1'b1;
            cnt_d          = cnt_t'(cnt_q - 1'b1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            ram_req_o.re   = 1'b1;
            ram_req_o.addr = front_q;
            front_d        = ptr_dec(front_q);
            res_d.pop_ok   = 1'b1;
            cnt_d          = cnt_t'(cnt_q - 1'b1);
          end
        end
        default: begin
          res_d.status = ST_DONE;
        end
      endcase
      res_d.occ = cnt_d;
    end
  end

  // result slot frees when taken, refills on a new transaction
  assign out_valid_d = acc || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q      <= '0;
      front_q     <= PTR_LAST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      back_q      <= back_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `RBD_ASSERT_ALWAYS(a_cnt_bound, (cnt_q <= DEPTH_CNT), "element count above depth")
  `RBD_ASSERT(a_full_push_drops, (acc && is_push && full) |=> ($stable(cnt_q) && $stable(back_q) && $stable(front_q)), "push on full changed state")
  `RBD_ASSERT(a_empty_pop_flag, (acc && !is_push && empty) |=> (out_valid_q && res_q.status == ST_EMPTY && !res_q.pop_ok), "pop on empty not flagged")
  `RBD_ASSERT(a_ram_single_op, !(ram_req_o.we && ram_req_o.re), "ram read and write in one cycle")
  `RBD_ASSERT(a_write_not_full, ram_req_o.we |-> !full, "ram write while full")

endmodule

`default_nettype wire

// ===== rtl/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque
// double-ended queue in a ring memory with push and pop at either end
// ----------------------------------------------------------------------------
// Takes one operation per clock cycle while the output accepts results (push
// back, push front, pop back, pop front) and returns exactly one result for
// each in the cycle after the input transaction, as the ring memory read is
// registered together with the result. A result waiting on m_axis_tready
// holds the input only while it is not being taken, so with the output always
// ready the rate is one transaction per cycle. No clearing pass is needed
// after reset. A pop on an empty queue and a push on a full queue leave the
// state untouched and are reported in the status.
`default_nettype none

module ring_buffer_deque (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // push_value[31:0]
  input  wire logic [rbd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // opcode[1:0]
  input  wire logic [rbd_pkg::OPCODE_W-1:0]      s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // pop_value[31:0], occupancy[36:32], zero fill[39:37]
  output logic      [rbd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic      [rbd_pkg::STATUS_W-1:0]      m_axis_tuser
);

  import rbd_pkg::*;

  ram_req_t ram_req;
  result_t  res;
  data_t    rdata;
  opcode_e  opcode;
  data_t    push_data;
  logic [VALUE_W-1:0] pop_value;
  logic [OCC_W-1:0]   occupancy;

  assign opcode    = opcode_e'(s_axis_tuser);
  assign push_data = DATA_WIDTH'(s_axis_tdata[VALUE_W-1:0]);

  rbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (opcode),
    .value_i     (push_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .ram_req_o   (ram_req)
  );

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.addr),
    .rdata_o (rdata)
  );

  // read data is only meaningful after a successful pop
  assign pop_value = res.pop_ok ? VALUE_W'(rdata) : '0;
  assign occupancy = OCC_W'(res.occ);

  assign m_axis_tdata = {{(M_TDATA_W - VALUE_W - OCC_W){1'b0}}, occupancy, pop_value};
  assign m_axis_tuser = res.status;

endmodule

`default_nettype wire
